@@ sv/dds_waveform_sample_generator_core_assert.svh @@
// Assertion macros shared by the waveform generator modules.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef DDS_WAVEFORM_SAMPLE_GENERATOR_CORE_ASSERT_SVH
`define DDS_WAVEFORM_SAMPLE_GENERATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define DWS_ASSERT(NAME, CLK, RSTN, PROP) \
    NAME: assert property (@(posedge CLK) disable iff (!RSTN) PROP) \
        else $error("dds assertion failed");

// Condition that must never be true outside reset.
`define DWS_ASSERT_NEVER(NAME, CLK, RSTN, EXPR) \
    NAME: assert property (@(posedge CLK) disable iff (!RSTN) !(EXPR)) \
        else $error("dds forbidden condition seen");

`else

`define DWS_ASSERT(NAME, CLK, RSTN, PROP)
`define DWS_ASSERT_NEVER(NAME, CLK, RSTN, EXPR)

`endif

`endif

@@ sv/dds_wsg_pkg.sv @@
package dds_wsg_pkg;

    // Default phase table size; the phase accumulator is log2 of this wide.
    localparam int DEF_TABLE_DEPTH = 256;

    // Output voltage range in millivolts.
    localparam int CENTER_MV = 1650;
    localparam int RAIL_MV   = 3300;

    // Entries in the queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // Field widths.
    localparam int MODE_W     = 2;
    localparam int WAVE_W     = 2;
    localparam int STEP_W     = 8;
    localparam int AMP_W      = 13;
    localparam int WORD_W     = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Mode codes.
    localparam logic [MODE_W-1:0] MODE_SILENT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GEN    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TRACK  = 2'd2;

    // Waveform codes.
    localparam logic [WAVE_W-1:0] WAVE_SIN = 2'd0;
    localparam logic [WAVE_W-1:0] WAVE_SQR = 2'd1;
    localparam logic [WAVE_W-1:0] WAVE_TRI = 2'd2;
    localparam logic [WAVE_W-1:0] WAVE_SAW = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RUNNING    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAVE_KIND  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AMP_MV     = 3'd4;

    // Full-scale DAC code.
    localparam logic [WORD_W-1:0] FULL_CODE = 12'd4095;

    // Scaling: num = (2v - 4095) * amp + CENTER_MV * 8190, held signed.
    localparam int NUM_W = 28;
    localparam logic signed [NUM_W-1:0] CENTER_TERM = NUM_W'(CENTER_MV * 8190);

    // Millivolts: floor(num / 8190) = floor((num >> 1) / 4095) by reciprocal.
    localparam int MV_W       = 13;
    localparam int MVX_W      = 25;
    localparam int MV_DIV_S   = MVX_W + 12;
    localparam logic [63:0] MV_DIV_M = ((64'd1 << MV_DIV_S) + 64'd4094) / 64'd4095;
    localparam int MV_M_W     = 26;
    localparam int MV_PROD_W  = MVX_W + MV_M_W;
    localparam logic [MV_W-1:0] RAIL_CODE = MV_W'(RAIL_MV);

    // DAC code: floor(mv * 4095 / RAIL_MV) by reciprocal.
    localparam int DAC_X_W    = 25;
    localparam int DAC_DIV_S  = DAC_X_W + $clog2(RAIL_MV);
    localparam logic [63:0] DAC_DIV_M =
        ((64'd1 << DAC_DIV_S) + 64'(RAIL_MV) - 64'd1) / 64'(RAIL_MV);
    localparam int DAC_M_W    = 27;
    localparam int DAC_PROD_W = DAC_X_W + DAC_M_W;

    // Sine in Q30 fixed point.
    localparam longint Q30_ONE = 64'sd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Class of a queued item.
    typedef enum logic {
        OP_PASS = 1'b0,
        OP_WAVE = 1'b1
    } op_t;

    // Configuration register bank.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              running;
        logic [WAVE_W-1:0] wave_kind;
        logic [STEP_W-1:0] phase_step;
        logic [AMP_W-1:0]  amp_mv;
    } cfg_t;

    // Quarter-wave sine entry for folded index idx of a 2^pw table.
    // Returns {code at -sin, code at +sin}, each floor((S + 2^30) * 4095 / 2^31).
    // Evaluated only at elaboration to build a constant table.
    function automatic logic [23:0] sine_codes(input int unsigned idx,
                                               input int unsigned pw);
        longint unsigned x;
        longint unsigned t;
        longint          s;
        longint unsigned up;
        longint unsigned dn;
        int unsigned     i;
        int unsigned     quarter;
        quarter = 32'd1 << (pw - 2);
        if (idx == 0) begin
            s = 0;
        end
        else if (idx >= quarter) begin
            s = Q30_ONE;
        end
        else begin
            x = ((64'(idx) * 64'd4) * HALF_PI_Q30) >> pw;
            t = x;
            s = longint'(x);
            for (i = 1; i <= 7; i++) begin
                t = (t * x) >> 30;
                t = (t * x) >> 30;
                case (i)
                    1:       t = t / 64'd6;
                    2:       t = t / 64'd20;
                    3:       t = t / 64'd42;
                    4:       t = t / 64'd72;
                    5:       t = t / 64'd110;
                    6:       t = t / 64'd156;
                    default: t = t / 64'd210;
                endcase
                if (i[0]) begin
                    s = s - longint'(t);
                end
                else begin
                    s = s + longint'(t);
                end
            end
            if (s < 0) begin
                s = 0;
            end
            if (s > Q30_ONE) begin
                s = Q30_ONE;
            end
        end
        up = (longint'(s + Q30_ONE) * 64'd4095) >> 31;
        dn = (longint'(Q30_ONE - s) * 64'd4095) >> 31;
        return {dn[11:0], up[11:0]};
    endfunction

endpackage

@@ sv/dds_waveform_sample_generator_core.sv @@
// Direct digital synthesis sample generator.
// Input channel (in_valid / in_stall) carries one sample tick per item with
// follow_valid and follow_word; an item is taken when in_valid is high and
// in_stall is low. Output channel (out_valid / out_stall) returns exactly
// one dac_word per input item, in order.
// Configuration is written through cfg_valid / cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high. Registers: 0 mode, 1 running,
// 2 wave_kind, 3 phase_step, 4 amp_mv. Other indexes are ignored.
// Path: an item taken is written into the queue, popped into back-end stage
// one, and passes stages two to four before its result is presented by the
// output register.
// Throughput: one item per cycle while the output is not stalled; the front
// phase accumulator updates once per item and the back end is fully pipelined.
// A stall on a valid output freezes the back-end stages; the four-entry queue
// keeps taking items until it fills, after which in_stall rises.
// Reset clears all configuration registers, the phase accumulator, the queue
// and every stage valid flag; the block then emits 0 for each item until
// configured.
module dds_waveform_sample_generator_core
    import dds_wsg_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  follow_valid,
    input  logic [WORD_W-1:0]     follow_word,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [WORD_W-1:0]     dac_word
);

    localparam int PW      = $clog2(TABLE_DEPTH);
    localparam int ENTRY_W = 1 + PW + WORD_W;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    logic               push;
    op_t                push_op;
    logic [PW-1:0]      push_phase;
    logic [WORD_W-1:0]  push_word;
    logic               q_full;
    logic               q_empty;
    logic               pop;
    logic [ENTRY_W-1:0] pop_data;

    // Configuration register bank.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_MODE:       cfg_next.mode       = cfg_data[MODE_W-1:0];
                REG_RUNNING:    cfg_next.running    = cfg_data[0];
                REG_WAVE_KIND:  cfg_next.wave_kind  = cfg_data[WAVE_W-1:0];
                REG_PHASE_STEP: cfg_next.phase_step = cfg_data[STEP_W-1:0];
                REG_AMP_MV:     cfg_next.amp_mv     = cfg_data[AMP_W-1:0];
                default:        cfg_next            = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg <= '0;
        end
        else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: takes items, advances the phase, classifies.
    dds_wsg_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .follow_valid (follow_valid),
        .follow_word  (follow_word),
        .q_full       (q_full),
        .push         (push),
        .push_op      (push_op),
        .push_phase   (push_phase),
        .push_word    (push_word)
    );

    // Queue between front and back.
    dds_wsg_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_op, push_phase, push_word}),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    // Back: waveform evaluation, scaling and output register.
    dds_wsg_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .pop       (pop),
        .pop_op    (op_t'(pop_data[ENTRY_W-1])),
        .pop_phase (pop_data[ENTRY_W-2:WORD_W]),
        .pop_word  (pop_data[WORD_W-1:0]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dac_word  (dac_word)
    );

endmodule

@@ sv/dds_wsg_queue.sv @@
`include "dds_waveform_sample_generator_core_assert.svh"

module dds_wsg_queue
    import dds_wsg_pkg::*;
#(
    parameter int WIDTH = 21,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots carry payload only.
    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    `DWS_ASSERT_NEVER(a_queue_overflow, clk, rst_n, push && full)
    `DWS_ASSERT_NEVER(a_queue_underflow, clk, rst_n, pop && empty)

endmodule

@@ sv/dds_wsg_front.sv @@
`include "dds_waveform_sample_generator_core_assert.svh"

module dds_wsg_front
    import dds_wsg_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  cfg_t                           cfg,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           follow_valid,
    input  logic [WORD_W-1:0]              follow_word,
    input  logic                           q_full,
    output logic                           push,
    output op_t                            push_op,
    output logic [$clog2(TABLE_DEPTH)-1:0] push_phase,
    output logic [WORD_W-1:0]              push_word
);

    localparam int PW    = $clog2(TABLE_DEPTH);
    localparam int SUM_W = ((PW > STEP_W) ? PW : STEP_W) + 1;

    logic [PW-1:0]    phase_reg;
    logic [PW-1:0]    phase_next;
    logic [SUM_W-1:0] phase_sum;
    logic             accept;
    logic             is_silent;

    // An item is taken whenever the queue has room.
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign push     = accept;

    // Phase advance, wrapping at the table size.
    assign phase_sum = SUM_W'(phase_reg) + SUM_W'(cfg.phase_step);

    // Classify the item and work out the phase it leaves behind.
    always_comb
    begin
        push_op    = OP_PASS;
        push_word  = '0;
        phase_next = phase_reg;
        is_silent  = 1'b0;
        if ((cfg.mode == MODE_GEN) && cfg.running) begin
            push_op    = OP_WAVE;
            phase_next = phase_sum[PW-1:0];
        end
        else if (cfg.mode == MODE_TRACK) begin
            push_word = follow_valid ? follow_word : '0;
        end
        else begin
            phase_next = '0;
            is_silent  = 1'b1;
        end
    end

    assign push_phase = phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= '0;
        end
        else if (accept) begin
            phase_reg <= phase_next;
        end
    end

    `DWS_ASSERT(a_silent_clears_phase, clk, rst_n, accept && is_silent |=> phase_reg == '0)

endmodule

@@ sv/dds_wsg_back.sv @@
`include "dds_waveform_sample_generator_core_assert.svh"

module dds_wsg_back
    import dds_wsg_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  cfg_t                           cfg,
    input  logic                           q_empty,
    output logic                           pop,
    input  op_t                            pop_op,
    input  logic [$clog2(TABLE_DEPTH)-1:0] pop_phase,
    input  logic [WORD_W-1:0]              pop_word,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [WORD_W-1:0]              dac_word
);

    localparam int PW      = $clog2(TABLE_DEPTH);
    localparam int QUARTER = TABLE_DEPTH / 4;
    localparam int RIDX_W  = PW - 1;
    localparam int TRI_W   = PW + 13;

    // Sawtooth: floor(p * 4095 / (N - 1)) by reciprocal multiply.
    localparam int SAW_X_W    = PW + 12;
    localparam int SAW_D      = TABLE_DEPTH - 1;
    localparam int SAW_S      = SAW_X_W + $clog2(SAW_D);
    localparam logic [63:0] SAW_M =
        ((64'd1 << SAW_S) + 64'(SAW_D) - 64'd1) / 64'(SAW_D);
    localparam int SAW_M_W    = SAW_X_W + 2;
    localparam int SAW_PROD_W = SAW_X_W + SAW_M_W;

    // Quarter-wave sine table, built at elaboration.
    logic [23:0] sine_rom [QUARTER+1];

    for (genvar gi = 0; gi <= QUARTER; gi++) begin : g_sine
        assign sine_rom[gi] = sine_codes(gi, PW);
    end

    logic advance;

    // Stage 1: waveform shape and sawtooth numerator.
    logic               s1_valid_reg;
    op_t                s1_op_reg;
    logic [WORD_W-1:0]  s1_word_reg;
    logic [WORD_W-1:0]  s1_shape_reg;
    logic [SAW_X_W-1:0] s1_saw_reg;

    logic [1:0]         quad;
    logic [RIDX_W-1:0]  ridx;
    logic [23:0]        sine_entry;
    logic [WORD_W-1:0]  sine_v;
    logic [WORD_W-1:0]  square_v;
    logic [PW:0]        tri_diff;
    logic [PW-1:0]      tri_p;
    logic [TRI_W-1:0]   tri_prod;
    logic [WORD_W-1:0]  shape_v;
    logic [SAW_X_W-1:0] saw_x;

    // Stage 2: waveform value.
    logic                  s2_valid_reg;
    op_t                   s2_op_reg;
    logic [WORD_W-1:0]     s2_word_reg;
    logic [WORD_W-1:0]     s2_v_reg;
    logic [SAW_PROD_W-1:0] saw_prod;
    logic [WORD_W-1:0]     wave_v;

    // Stage 3: scaled numerator.
    logic                    s3_valid_reg;
    op_t                     s3_op_reg;
    logic [WORD_W-1:0]       s3_word_reg;
    logic signed [NUM_W-1:0] s3_num_reg;
    logic signed [13:0]      swing;
    logic signed [13:0]      amp_s;
    logic signed [NUM_W-1:0] num;

    // Stage 4: clamped millivolts.
    logic                 s4_valid_reg;
    op_t                  s4_op_reg;
    logic [WORD_W-1:0]    s4_word_reg;
    logic [MV_W-1:0]      s4_mv_reg;
    logic [MVX_W-1:0]     mv_x;
    logic [MV_PROD_W-1:0] mv_prod;
    logic [MV_W-1:0]      mv_q;
    logic [MV_W-1:0]      mv;

    // Stage 5: DAC code in the output register.
    logic                  out_valid_reg;
    logic [WORD_W-1:0]     dac_reg;
    logic [DAC_X_W-1:0]    dac_x;
    logic [DAC_PROD_W-1:0] dac_prod;
    logic [WORD_W-1:0]     dac_code;

    // The whole line moves unless a finished item is held by the receiver.
    assign advance   = !(out_valid_reg && out_stall);
    assign pop       = advance && !q_empty;
    assign out_valid = out_valid_reg;
    assign dac_word  = dac_reg;

    // Stage 1 logic: fold the phase into the quarter table, build other shapes.
    always_comb
    begin
        quad       = pop_phase[PW-1:PW-2];
        ridx       = quad[0] ? (RIDX_W'(QUARTER) - RIDX_W'(pop_phase[PW-3:0]))
                             : RIDX_W'(pop_phase[PW-3:0]);
        sine_entry = sine_rom[ridx];
        sine_v     = quad[1] ? sine_entry[23:12] : sine_entry[11:0];
        square_v   = pop_phase[PW-1] ? '0 : FULL_CODE;
        tri_diff   = (PW+1)'(TABLE_DEPTH) - {1'b0, pop_phase};
        tri_p      = pop_phase[PW-1] ? tri_diff[PW-1:0] : pop_phase;
        tri_prod   = TRI_W'(tri_p) * TRI_W'(8190);
        saw_x      = (SAW_X_W'(pop_phase) << 12) - SAW_X_W'(pop_phase);
        case (cfg.wave_kind)
            WAVE_SIN: shape_v = sine_v;
            WAVE_SQR: shape_v = square_v;
            WAVE_TRI: shape_v = tri_prod[PW+11:PW];
            default:  shape_v = '0;
        endcase
    end

    // Stage 2 logic: sawtooth quotient.
    always_comb
    begin
        saw_prod = SAW_PROD_W'(s1_saw_reg) * SAW_PROD_W'(SAW_M[SAW_M_W-1:0]);
        wave_v   = (cfg.wave_kind == WAVE_SAW) ? saw_prod[SAW_S+11:SAW_S] : s1_shape_reg;
    end

    // Stage 3 logic: swing around center times amplitude.
    always_comb
    begin
        swing = $signed({1'b0, s2_v_reg, 1'b0}) - 14'sd4095;
        amp_s = $signed({1'b0, cfg.amp_mv});
        num   = NUM_W'(swing) * NUM_W'(amp_s) + CENTER_TERM;
    end

    // Stage 4 logic: divide by 8190 and clamp between zero and the rail.
    always_comb
    begin
        mv_x    = s3_num_reg[MVX_W:1];
        mv_prod = MV_PROD_W'(mv_x) * MV_PROD_W'(MV_DIV_M[MV_M_W-1:0]);
        mv_q    = mv_prod[MV_DIV_S+MV_W-1:MV_DIV_S];
        if (s3_num_reg < 0) begin
            mv = '0;
        end
        else if (mv_q > RAIL_CODE) begin
            mv = RAIL_CODE;
        end
        else begin
            mv = mv_q;
        end
    end

    // Stage 5 logic: millivolts to DAC code, or the queued word for pass items.
    always_comb
    begin
        dac_x    = (DAC_X_W'(s4_mv_reg) << 12) - DAC_X_W'(s4_mv_reg);
        dac_prod = DAC_PROD_W'(dac_x) * DAC_PROD_W'(DAC_DIV_M[DAC_M_W-1:0]);
        dac_code = (s4_op_reg == OP_WAVE) ? dac_prod[DAC_DIV_S+11:DAC_DIV_S]
                                          : s4_word_reg;
    end

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance) begin
            s1_valid_reg  <= pop;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (advance) begin
            s1_op_reg    <= pop_op;
            s1_word_reg  <= pop_word;
            s1_shape_reg <= shape_v;
            s1_saw_reg   <= saw_x;
            s2_op_reg    <= s1_op_reg;
            s2_word_reg  <= s1_word_reg;
            s2_v_reg     <= wave_v;
            s3_op_reg    <= s2_op_reg;
            s3_word_reg  <= s2_word_reg;
            s3_num_reg   <= num;
            s4_op_reg    <= s3_op_reg;
            s4_word_reg  <= s3_word_reg;
            s4_mv_reg    <= mv;
            dac_reg      <= dac_code;
        end
    end

    `DWS_ASSERT_NEVER(a_no_pop_while_held, clk, rst_n, out_valid_reg && out_stall && pop)
    `DWS_ASSERT(a_pop_enters_stage1, clk, rst_n, pop |=> s1_valid_reg)

endmodule
